>>> design/delimited_field_extractor_macros.svh
// ----------------------------------------------------------------------------
// Delimited field extractor assertion macros
// Shared concurrent assertion shorthands for the extractor modules.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FIELD_EXTRACTOR_MACROS_SVH
`define DELIMITED_FIELD_EXTRACTOR_MACROS_SVH

// Checked on every rising edge of clk while arst_n is high.
`define DFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also during reset.
`define DFE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dfe_pkg.sv
// ----------------------------------------------------------------------------
// Delimited field extractor package
// Constants, register indexes and shared types of the field extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfe_pkg;

	// Highest field number that the mask can select.
	localparam int MAX_FIELDS = 64;
	// Field counter saturates one past the selectable range.
	localparam int FIELD_CAP  = MAX_FIELDS + 1;
	localparam int FNUM_W     = $clog2(FIELD_CAP + 1);

	localparam int BYTE_W     = 8;
	localparam int MASK_W     = 64;
	localparam int CFG_IDX_W  = 8;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [BYTE_W-1:0] TAB_BYTE     = 8'h09;

	// Result queue between the step logic and the output channel.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELIMITER  = 8'd0,
		CFG_FIELD_MASK = 8'd1
	} cfg_reg_t;

	// One output word.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} result_t;

	// Words produced by one input byte, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} step_out_t;

endpackage

>>> design/dfe_if.sv
// ----------------------------------------------------------------------------
// Delimited field extractor channel interfaces
// Valid/ready channels for input bytes, output words and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dfe_byte_if import dfe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface dfe_result_if import dfe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface dfe_cfg_if import dfe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [MASK_W-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> design/delimited_field_extractor.sv
// ----------------------------------------------------------------------------
// Delimited field extractor
// Passes the mask-selected delimiter-separated fields of each text line.
//
//   Channel   Direction  Handshake      Word contents
//   ingress   in         valid/ready    data_byte
//   egress    out        valid/ready    out_byte, last
//   cfg       in         valid/ready    index, wdata (ready always high)
//
// A byte is captured in the input register and decoded from there,
// writing zero, one or two words into a four-word result queue.
// The output side drains one word per cycle while egress.ready is high, so
// the sustained rate is one byte per cycle; an inserted delimiter adds a word.
// The input register drains only while the queue has two free words;
// a stalled output backs up into ingress.ready. Reset is asynchronous and
// restores the line state, delimiter tab and an empty field mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delimited_field_extractor
	import dfe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	dfe_byte_if.sink            ingress,
	dfe_result_if.source        egress,
	dfe_cfg_if.sink             cfg
);

`include "delimited_field_extractor_macros.svh"

	logic [BYTE_W-1:0]   delimiter_q;
	logic [MASK_W-1:0]   field_mask_q;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                drain_s1;

	step_out_t           step_out;

	result_t             rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] count_q;
	logic [RQ_CNT_W-1:0] push_cnt;
	logic                pop;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q  <= TAB_BYTE;
			field_mask_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DELIMITER:  delimiter_q  <= cfg.wdata[BYTE_W-1:0];
				CFG_FIELD_MASK: field_mask_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Input register; it drains when the queue can take two words.
	assign drain_s1      = valid_s1 && (count_q <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign ingress.ready = !valid_s1 || drain_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ingress.ready) begin
			valid_s1 <= ingress.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ingress.ready && ingress.valid) begin
			byte_s1 <= ingress.data_byte;
		end
	end

	dfe_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (drain_s1),
		.data_byte  (byte_s1),
		.delimiter  (delimiter_q),
		.field_mask (field_mask_q),
		.step_out   (step_out)
	);

	// Result queue.
	assign push_cnt = drain_s1 ? RQ_CNT_W'(step_out.count) : '0;
	assign pop      = egress.valid && egress.ready;

	always_ff @(posedge clk) begin
		if (drain_s1 && (step_out.count != 2'd0)) begin
			rq_q[wr_ptr_q] <= step_out.res0;
		end
		if (drain_s1 && (step_out.count == 2'd2)) begin
			rq_q[wr_ptr_q + RQ_PTR_W'(1)] <= step_out.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt[RQ_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			count_q <= count_q + push_cnt - RQ_CNT_W'(pop);
		end
	end

	// Output word from the queue head.
	assign egress.valid    = (count_q != '0);
	assign egress.out_byte = rq_q[rd_ptr_q].out_byte;
	assign egress.last     = rq_q[rd_ptr_q].last;

	`DFE_ASSERT_ALWAYS(a_rq_bound, count_q <= RQ_CNT_W'(RQ_DEPTH), "result queue overflow")
	`DFE_ASSERT(a_drain_room, drain_s1 |-> (count_q + RQ_CNT_W'(step_out.count) - RQ_CNT_W'(pop) <= RQ_CNT_W'(RQ_DEPTH)), "queue push without room")
	`DFE_ASSERT(a_sep_followed, (egress.valid && !egress.last) |-> (count_q >= RQ_CNT_W'(2)), "separator queued without its byte")

endmodule

>>> design/dfe_step.sv
// ----------------------------------------------------------------------------
// Delimited field extractor line state and step logic
// Holds the per-line field state and decodes one byte into up to two words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfe_step
	import dfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [BYTE_W-1:0] delimiter,
	input  logic [MASK_W-1:0] field_mask,
	output step_out_t         step_out
);

`include "delimited_field_extractor_macros.svh"

	logic [FNUM_W-1:0] field_number_q;
	logic              at_field_start_q;
	logic              field_active_q;
	logic              emitted_on_line_q;

	logic [FNUM_W-1:0] field_number_d;
	logic              at_field_start_d;
	logic              field_active_d;
	logic              emitted_on_line_d;

	logic              is_newline;
	logic              is_delim;
	logic              in_range;
	logic [MASK_W-1:0] mask_shifted;
	logic              selected;
	logic              active;
	logic              insert_sep;

	// Selection of the current field number by the mask.
	assign in_range     = (field_number_q != '0) &&
	                      (field_number_q <= FNUM_W'(MAX_FIELDS));
	assign mask_shifted = field_mask >> (field_number_q - FNUM_W'(1));
	assign selected     = in_range && mask_shifted[0];

	// Newline wins over the delimiter when both match.
	assign is_newline = (data_byte == NEWLINE_BYTE);
	assign is_delim   = !is_newline && (data_byte == delimiter);

	assign active     = at_field_start_q ? selected : field_active_q;
	assign insert_sep = at_field_start_q && selected && emitted_on_line_q;

	// Next state and the words caused by this byte.
	always_comb begin
		field_number_d    = field_number_q;
		at_field_start_d  = at_field_start_q;
		field_active_d    = field_active_q;
		emitted_on_line_d = emitted_on_line_q;
		step_out          = '0;
		if (is_newline) begin
			step_out.count         = 2'd1;
			step_out.res0.out_byte = NEWLINE_BYTE;
			step_out.res0.last     = 1'b1;
			field_number_d         = FNUM_W'(1);
			at_field_start_d       = 1'b1;
			field_active_d         = 1'b0;
			emitted_on_line_d      = 1'b0;
		end else if (is_delim) begin
			if (field_number_q < FNUM_W'(FIELD_CAP)) begin
				field_number_d = field_number_q + FNUM_W'(1);
			end
			at_field_start_d = 1'b1;
			field_active_d   = 1'b0;
		end else begin
			at_field_start_d  = 1'b0;
			field_active_d    = active;
			emitted_on_line_d = emitted_on_line_q | active;
			if (insert_sep) begin
				step_out.count         = 2'd2;
				step_out.res0.out_byte = delimiter;
				step_out.res0.last     = 1'b0;
				step_out.res1.out_byte = data_byte;
				step_out.res1.last     = 1'b1;
			end else if (active) begin
				step_out.count         = 2'd1;
				step_out.res0.out_byte = data_byte;
				step_out.res0.last     = 1'b1;
			end
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_number_q    <= FNUM_W'(1);
			at_field_start_q  <= 1'b1;
			field_active_q    <= 1'b0;
			emitted_on_line_q <= 1'b0;
		end else if (fire) begin
			field_number_q    <= field_number_d;
			at_field_start_q  <= at_field_start_d;
			field_active_q    <= field_active_d;
			emitted_on_line_q <= emitted_on_line_d;
		end
	end

	`DFE_ASSERT(a_fnum_range, (field_number_q != '0) && (field_number_q <= FNUM_W'(FIELD_CAP)), "field number out of range")
	`DFE_ASSERT(a_active_not_start, field_active_q |-> !at_field_start_q, "active field still at start")
	`DFE_ASSERT(a_newline_restart, (fire && is_newline) |=> (field_number_q == FNUM_W'(1)) && at_field_start_q && !emitted_on_line_q, "newline did not restart line")

endmodule
